FILE: rtl/core/pia_pkg.sv
// shared types and constants for the packed int32x4 alu
`timescale 1ns / 1ps

package pia_pkg;

    // lane geometry
    localparam int LANE_W         = 32;
    localparam int FIELD_LANES    = 4;
    localparam int VEC_W          = LANE_W * FIELD_LANES;
    localparam int SHIFT_W        = 5;
    localparam int CMD_W          = 5;
    localparam int COUNT_W        = 32;
    localparam int LANE_COUNT_DEF = 4;

    // input beat layout, lowest bit first
    localparam int CMD_LSB        = 0;
    localparam int A_LSB          = CMD_LSB + CMD_W;
    localparam int B_LSB          = A_LSB + VEC_W;
    localparam int C_LSB          = B_LSB + VEC_W;
    localparam int SHIFT_LSB      = C_LSB + VEC_W;
    localparam int IN_BITS        = SHIFT_LSB + COUNT_W;
    localparam int IN_TDATA_W     = ((IN_BITS + 7) / 8) * 8;

    // output beat layout
    localparam int OUT_TDATA_W    = VEC_W;
    localparam int OUT_TUSER_W    = 1;

    typedef logic [LANE_W-1:0] lane_t;
    typedef lane_t [FIELD_LANES-1:0] vec_t;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 5'd0,
        CMD_SUB    = 5'd1,
        CMD_MUL    = 5'd2,
        CMD_AND    = 5'd3,
        CMD_OR     = 5'd4,
        CMD_XOR    = 5'd5,
        CMD_NOT    = 5'd6,
        CMD_NEG    = 5'd7,
        CMD_ABS    = 5'd8,
        CMD_MIN    = 5'd9,
        CMD_MAX    = 5'd10,
        CMD_LT     = 5'd11,
        CMD_LE     = 5'd12,
        CMD_EQ     = 5'd13,
        CMD_NE     = 5'd14,
        CMD_GT     = 5'd15,
        CMD_GE     = 5'd16,
        CMD_SHL    = 5'd17,
        CMD_SRA    = 5'd18,
        CMD_SELECT = 5'd19,
        CMD_SPLAT  = 5'd20,
        CMD_PASS   = 5'd21
    } cmd_e;

    localparam cmd_e CMD_LAST = CMD_PASS;

endpackage

FILE: rtl/core/pia_lane.sv
// one 32-bit lane of the packed alu: all commands for a single lane
`timescale 1ns / 1ps

module pia_lane (
    input  pia_pkg::cmd_e                    cmd,
    input  pia_pkg::lane_t                   a,
    input  pia_pkg::lane_t                   b,
    input  pia_pkg::lane_t                   c,
    input  pia_pkg::lane_t                   a0,
    input  logic [pia_pkg::SHIFT_W-1:0]      sh,
    output pia_pkg::lane_t                   result
);
    import pia_pkg::*;

    lane_t neg_a;
    lane_t prod;
    logic  a_lt_b;
    logic  b_lt_a;
    logic  a_eq_b;

    // shared pieces
    assign neg_a  = ~a + lane_t'(1);
    assign prod   = a * b;
    assign a_lt_b = $signed(a) < $signed(b);
    assign b_lt_a = $signed(b) < $signed(a);
    assign a_eq_b = (a == b);

    // command select
    always_comb
    begin
        case (cmd)
            CMD_ADD:    result = a + b;
            CMD_SUB:    result = a - b;
            CMD_MUL:    result = prod;
            CMD_AND:    result = a & b;
            CMD_OR:     result = a | b;
            CMD_XOR:    result = a ^ b;
            CMD_NOT:    result = ~a;
            CMD_NEG:    result = neg_a;
            CMD_ABS:    result = a[LANE_W-1] ? neg_a : a;
            CMD_MIN:    result = a_lt_b ? a : b;
            CMD_MAX:    result = b_lt_a ? a : b;
            CMD_LT:     result = {LANE_W{a_lt_b}};
            CMD_LE:     result = {LANE_W{~b_lt_a}};
            CMD_EQ:     result = {LANE_W{a_eq_b}};
            CMD_NE:     result = {LANE_W{~a_eq_b}};
            CMD_GT:     result = {LANE_W{b_lt_a}};
            CMD_GE:     result = {LANE_W{~a_lt_b}};
            CMD_SHL:    result = a << sh;
            CMD_SRA:    result = lane_t'($signed(a) >>> sh);
            CMD_SELECT: result = (a & c) | (b & ~c);
            CMD_SPLAT:  result = a0;
            CMD_PASS:   result = a;
            default:    result = '0;
        endcase
    end

endmodule

FILE: rtl/core/packed_int32x4_alu.sv
// top level of the packed int32x4 alu: input register, lane units, result register
`timescale 1ns / 1ps

// Packed integer ALU over four 32-bit two's-complement lanes. Each input beat
// carries a command, vectors a, b and c and a shift count; each one gives
// exactly one output beat. An accepted input beat passes through the input
// register, then the result register, to a valid output beat, and a new beat
// is taken every cycle as long as the output side keeps up; the lane logic
// between the registers (the 32x32 low-word multiplier is its longest path)
// is combinational. Unknown commands give a zero result with tuser set.
// Lanes at or above LANE_COUNT read as zero.

module packed_int32x4_alu #(
    parameter int LANE_COUNT = pia_pkg::LANE_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // command, a lanes 0-3, b lanes 0-3, c lanes 0-3, shift_count, zero pad
    input  logic [pia_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // result_lanes_01, result_lanes_23
    output logic [pia_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // bad_command
    output logic [pia_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready
);
    import pia_pkg::*;

    logic                     in_valid_reg;
    cmd_e                     cmd_reg;
    vec_t                     a_reg;
    vec_t                     b_reg;
    vec_t                     c_reg;
    logic [SHIFT_W-1:0]       sh_reg;

    logic                     out_valid_reg;
    vec_t                     res_reg;
    logic                     bad_reg;

    logic                     out_free;
    logic                     advance;
    logic                     bad_cmd;
    vec_t                     lane_res;
    vec_t                     res_next;

    // pipeline flow control
    assign out_free      = ~out_valid_reg | m_axis_tready;
    assign advance       = in_valid_reg & out_free;
    assign s_axis_tready = ~in_valid_reg | out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg <= cmd_e'(s_axis_tdata[CMD_LSB +: CMD_W]);
            a_reg   <= s_axis_tdata[A_LSB +: VEC_W];
            b_reg   <= s_axis_tdata[B_LSB +: VEC_W];
            c_reg   <= s_axis_tdata[C_LSB +: VEC_W];
            sh_reg  <= s_axis_tdata[SHIFT_LSB +: SHIFT_W];
        end
    end

    // lane units, unused lanes tied to zero
    for (genvar i = 0; i < FIELD_LANES; i++)
    begin : g_lane
        if (i < LANE_COUNT)
        begin : g_on
            pia_lane u_lane (
                .cmd    (cmd_reg),
                .a      (a_reg[i]),
                .b      (b_reg[i]),
                .c      (c_reg[i]),
                .a0     (a_reg[0]),
                .sh     (sh_reg),
                .result (lane_res[i])
            );
        end
        else
        begin : g_off
            assign lane_res[i] = '0;
        end
    end

    // unknown command forces zero
    assign bad_cmd  = (cmd_reg > CMD_LAST);
    assign res_next = bad_cmd ? '0 : lane_res;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
            bad_reg <= bad_cmd;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = res_reg;
    assign m_axis_tuser  = bad_reg;

    // checks on pipeline behavior
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("bad command beat carries nonzero data");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat did not reach result register");

    a_flag_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (bad_reg == $past(cmd_reg > CMD_LAST)))
        else $error("bad command flag does not match command");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("empty input stage not ready");

endmodule
